// ===== rtl/rcp_pkg.sv =====
`timescale 1ns / 1ps

package rcp_pkg;

	// Frame layout
	localparam int FRAME_BYTES = 28;
	localparam int POS_W       = 5;

	typedef logic [POS_W-1:0] pos_t;

	localparam logic [POS_W:0] FRAME_LEN = (POS_W+1)'(FRAME_BYTES);

	localparam logic [7:0] SYNC_HI = 8'hAA;
	localparam logic [7:0] SYNC_LO = 8'h55;
	localparam logic [7:0] VERSION = 8'h01;
	localparam logic [7:0] LENGTH  = 8'h16;

	// Byte offsets within a frame
	localparam pos_t OFS_VERSION = 5'd2;
	localparam pos_t OFS_LENGTH  = 5'd3;
	localparam pos_t OFS_CHAN    = 5'd4;
	localparam pos_t OFS_FLAGS   = 5'd24;
	localparam pos_t OFS_CRC_END = 5'd25;
	localparam pos_t OFS_CRC_LO  = 5'd26;
	localparam pos_t OFS_CRC_HI  = 5'd27;

	// bytes rescanned after a rejected frame (sync pair dropped)
	localparam logic [POS_W-1:0] REPLAY_BYTES = 5'd26;

	localparam int FAILSAFE_BIT = 1;

	localparam logic [15:0] CRC_POLY = 16'h1021;

	localparam logic [3:0] LAST_CHANNEL = 4'd9;

	// Pulse scaling: 16000 + floor((d*16000 + 819) / 1638), d = clamp(raw) - 172
	localparam logic [15:0] RAW_MIN     = 16'd172;
	localparam logic [15:0] RAW_MAX     = 16'd1810;
	localparam logic [13:0] SCALE_MUL   = 14'd16000;
	localparam logic [24:0] SCALE_BIAS  = 25'd819;
	localparam logic [14:0] RECIP       = 15'd20485;  // floor(2^25 / 1638)
	localparam int          RECIP_SHIFT = 25;
	localparam logic [10:0] DIVISOR     = 11'd1638;
	localparam logic [14:0] PULSE_MIN   = 15'd16000;
	localparam logic [14:0] PULSE_MAX   = 15'd32000;

	typedef enum logic [1:0] {
		HP_IDLE,
		HP_HOLD,
		HP_SYNC
	} hunt_phase_t;

	typedef enum logic [2:0] {
		CS_IDLE,
		CS_REPLAY,
		CS_RD_LO,
		CS_RD_HI,
		CS_START,
		CS_SCALE
	} ctl_state_t;

	// One byte presented to the sync hunter
	typedef struct packed {
		logic       valid;
		logic [7:0] data;
		pos_t       pos;
	} hunt_feed_t;

	// Hunter status back to the controller
	typedef struct packed {
		logic done;
		logic ok;
		logic link_ok;
		pos_t base;
	} hunt_stat_t;

	// Position in the circular frame memory, modulo the frame length
	function automatic pos_t pos_add(input pos_t pos, input pos_t ofs);
		logic [POS_W:0] sum;
		sum = {1'b0, pos} + {1'b0, ofs};
		if (sum >= FRAME_LEN) begin
			sum = sum - FRAME_LEN;
		end
		return sum[POS_W-1:0];
	endfunction

	// CRC-16/XMODEM, one byte, MSB first
	function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] data);
		logic [15:0] c;
		c = crc ^ {data, 8'h00};
		for (int b = 0; b < 8; b++) begin
			if (c[15]) begin
				c = {c[14:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[14:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

// ===== rtl/rcp_frame_ram.sv =====
`timescale 1ns / 1ps

module rcp_frame_ram import rcp_pkg::*; (
	input  logic       clk,
	input  logic       we,
	input  pos_t       waddr,
	input  logic [7:0] wdata,
	input  logic       re,
	input  pos_t       raddr,
	output logic [7:0] rdata
);

	logic [7:0] mem [FRAME_BYTES];

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== rtl/rcp_hunt.sv =====
`timescale 1ns / 1ps

module rcp_hunt import rcp_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  hunt_feed_t feed,
	output hunt_stat_t stat
);

	hunt_phase_t phase_q, phase_d;
	pos_t        cnt_q;       // frame offset of the next byte
	pos_t        base_q;      // memory position of the frame's first sync byte
	logic [15:0] crc_q;
	logic        hdr_ok_q;
	logic [7:0]  crc_lo_q;
	logic        link_q;
	logic        in_sync;
	logic        frame_end;

	assign in_sync = feed.valid && (phase_q == HP_SYNC);

	// Next phase
	always_comb begin
		phase_d = phase_q;
		if (feed.valid) begin
			case (phase_q)
				HP_IDLE: begin
					if (feed.data == SYNC_HI) begin
						phase_d = HP_HOLD;
					end
				end
				HP_HOLD: begin
					if (feed.data == SYNC_LO) begin
						phase_d = HP_SYNC;
					end else if (feed.data != SYNC_HI) begin
						phase_d = HP_IDLE;
					end
				end
				HP_SYNC: begin
					if (cnt_q == OFS_CRC_HI) begin
						phase_d = HP_IDLE;
					end
				end
				default: phase_d = HP_IDLE;
			endcase
		end
	end

	// Status: frame closes on its last CRC byte
	always_comb begin
		frame_end    = in_sync && (cnt_q == OFS_CRC_HI);
		stat.done    = frame_end;
		stat.ok      = hdr_ok_q && (crc_q == {feed.data, crc_lo_q});
		stat.link_ok = link_q;
		stat.base    = base_q;
	end

	// Phase, offset and frame start
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= HP_IDLE;
			cnt_q   <= '0;
			base_q  <= '0;
		end else begin
			phase_q <= phase_d;
			if (feed.valid) begin
				if (phase_q != HP_SYNC && feed.data == SYNC_HI) begin
					base_q <= feed.pos;
				end
				if (phase_q == HP_HOLD) begin
					cnt_q <= OFS_VERSION;
				end else if (phase_q == HP_SYNC) begin
					cnt_q <= cnt_q + 5'd1;
				end
			end
		end
	end

	// Header check, running CRC, flags and received CRC
	always_ff @(posedge clk) begin
		if (in_sync) begin
			if (cnt_q == OFS_VERSION) begin
				hdr_ok_q <= (feed.data == VERSION);
			end
			if (cnt_q == OFS_LENGTH) begin
				hdr_ok_q <= hdr_ok_q && (feed.data == LENGTH);
			end
			if (cnt_q <= OFS_CRC_END) begin
				crc_q <= crc_step(crc_q, feed.data);
			end
			if (cnt_q == OFS_FLAGS) begin
				link_q <= !feed.data[FAILSAFE_BIT];
			end
			if (cnt_q == OFS_CRC_LO) begin
				crc_lo_q <= feed.data;
			end
		end else if (feed.valid && phase_q == HP_HOLD) begin
			crc_q <= '0;
		end
	end

endmodule

// ===== rtl/rcp_scale.sv =====
`timescale 1ns / 1ps

module rcp_scale import rcp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [15:0] raw,
	output logic        done,
	output logic [14:0] pulse
);

	logic [10:0] delta;
	logic [24:0] y_d, y_s1, y_s2, y_s3;
	logic [39:0] prod;
	logic [13:0] q_s2, q_s3;
	logic [24:0] t_d, t_s3;
	logic [24:0] rem;
	logic        bump;
	logic        v_s1, v_s2, v_s3;
	logic        done_q;
	logic [14:0] pulse_q;

	// Stage 1: clamp, offset, numerator
	always_comb begin
		if (raw < RAW_MIN) begin
			delta = '0;
		end else if (raw > RAW_MAX) begin
			delta = 11'(RAW_MAX - RAW_MIN);
		end else begin
			delta = 11'(raw - RAW_MIN);
		end
		y_d = 25'(delta) * 25'(SCALE_MUL) + SCALE_BIAS;
	end

	// Stage 2: reciprocal estimate, low by at most one
	assign prod = 40'(y_s1) * 40'(RECIP);

	// Stage 3: back-multiply estimate
	assign t_d = 25'(q_s2) * 25'(DIVISOR);

	// Stage 4: remainder correction
	assign rem  = y_s3 - t_s3;
	assign bump = (rem >= 25'(DIVISOR));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			v_s2   <= 1'b0;
			v_s3   <= 1'b0;
			done_q <= 1'b0;
		end else begin
			v_s1 <= start;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			if (start) begin
				done_q <= 1'b0;
			end else if (v_s3) begin
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		y_s1 <= y_d;
		y_s2 <= y_s1;
		q_s2 <= prod[RECIP_SHIFT +: 14];
		y_s3 <= y_s2;
		q_s3 <= q_s2;
		t_s3 <= t_d;
		if (v_s3) begin
			pulse_q <= PULSE_MIN + 15'(q_s3) + 15'(bump);
		end
	end

	assign done  = done_q;
	assign pulse = pulse_q;

endmodule

// ===== rtl/crc16_framed_rc_channel_parser_core.sv =====
`timescale 1ns / 1ps
// A byte that closes a valid frame starts the read, start and scale states that give its first result.
// Throughput: one byte per cycle while collecting; a valid frame then holds the input while its
// ten channels are emitted, each with two frame memory reads plus the four-stage scaler.
// A rejected frame holds the input while 26 bytes are rescanned via the read port.
// Reset (arst_n low, asynchronous): hunt, counters and output valid clear; memory is not cleared.
module crc16_framed_rc_channel_parser_core import rcp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  rx_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [3:0]  channel_index,
	output logic [14:0] pulse_sixteenths,
	output logic        link_ok,
	output logic [15:0] frame_count,
	output logic        last_channel
);

	ctl_state_t  state_q, state_d;
	pos_t        wr_q;
	pos_t        base_q;
	logic [4:0]  rep_cnt_q;
	logic        rp_v_s1;
	pos_t        rp_pos_s1;
	logic [3:0]  ch_q;
	logic [7:0]  lo_q;
	logic [15:0] count_q;

	logic        out_valid_q;
	logic [3:0]  chan_idx_q;
	logic [14:0] pulse_q;
	logic        link_q;
	logic [15:0] fcount_q;
	logic        last_q;

	logic        in_accept;
	logic        rep_issue;
	logic        slot_free;
	logic        push;
	pos_t        chan_ofs;
	logic        ram_re;
	pos_t        ram_raddr;
	logic [7:0]  ram_rdata;
	hunt_feed_t  feed;
	hunt_stat_t  stat;
	logic        scale_start;
	logic        scale_done;
	logic [14:0] scale_pulse;

	rcp_frame_ram u_ram (
		.clk   (clk),
		.we    (in_accept),
		.waddr (wr_q),
		.wdata (rx_byte),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	rcp_hunt u_hunt (
		.clk    (clk),
		.arst_n (arst_n),
		.feed   (feed),
		.stat   (stat)
	);

	rcp_scale u_scale (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (scale_start),
		.raw    ({ram_rdata, lo_q}),
		.done   (scale_done),
		.pulse  (scale_pulse)
	);

	assign rep_issue = (state_q == CS_REPLAY) && (rep_cnt_q != REPLAY_BYTES);
	assign slot_free = !out_valid_q || !out_stall;
	assign chan_ofs  = OFS_CHAN + {ch_q, 1'b0};

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			CS_IDLE: begin
				if (in_accept && stat.done) begin
					state_d = stat.ok ? CS_RD_LO : CS_REPLAY;
				end
			end
			CS_REPLAY: begin
				if (!rep_issue && !rp_v_s1) begin
					state_d = CS_IDLE;
				end
			end
			CS_RD_LO: state_d = CS_RD_HI;
			CS_RD_HI: state_d = CS_START;
			CS_START: state_d = CS_SCALE;
			CS_SCALE: begin
				if (push) begin
					state_d = (ch_q == LAST_CHANNEL) ? CS_IDLE : CS_RD_LO;
				end
			end
			default: state_d = CS_IDLE;
		endcase
	end

	// Control outputs
	always_comb begin
		in_stall    = (state_q != CS_IDLE);
		in_accept   = in_valid && (state_q == CS_IDLE);
		scale_start = (state_q == CS_START);
		push        = (state_q == CS_SCALE) && scale_done && slot_free;
		ram_re      = 1'b0;
		ram_raddr   = base_q;
		case (state_q)
			CS_REPLAY: begin
				ram_re    = rep_issue;
				ram_raddr = pos_add(base_q, OFS_VERSION + rep_cnt_q);
			end
			CS_RD_LO: begin
				ram_re    = 1'b1;
				ram_raddr = pos_add(base_q, chan_ofs);
			end
			CS_RD_HI: begin
				ram_re    = 1'b1;
				ram_raddr = pos_add(base_q, chan_ofs + 5'd1);
			end
			default: begin
				ram_re    = 1'b0;
				ram_raddr = base_q;
			end
		endcase
		// hunter sees new bytes, or rescanned bytes during replay
		feed.valid = in_accept || ((state_q == CS_REPLAY) && rp_v_s1);
		feed.data  = (state_q == CS_REPLAY) ? ram_rdata : rx_byte;
		feed.pos   = (state_q == CS_REPLAY) ? rp_pos_s1 : wr_q;
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= CS_IDLE;
			wr_q        <= '0;
			base_q      <= '0;
			rep_cnt_q   <= '0;
			rp_v_s1     <= 1'b0;
			ch_q        <= '0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			rp_v_s1 <= rep_issue;
			if (in_accept) begin
				wr_q      <= pos_add(wr_q, 5'd1);
				rep_cnt_q <= '0;
				ch_q      <= '0;
				if (stat.done) begin
					base_q <= stat.base;
					if (stat.ok) begin
						count_q <= count_q + 16'd1;
					end
				end
			end
			if (rep_issue) begin
				rep_cnt_q <= rep_cnt_q + 5'd1;
			end
			if (push) begin
				ch_q <= ch_q + 4'd1;
			end
			if (push) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		rp_pos_s1 <= ram_raddr;
		if (state_q == CS_RD_HI) begin
			lo_q <= ram_rdata;
		end
		if (push) begin
			chan_idx_q <= ch_q;
			pulse_q    <= scale_pulse;
			link_q     <= stat.link_ok;
			fcount_q   <= count_q;
			last_q     <= (ch_q == LAST_CHANNEL);
		end
	end

	assign out_valid        = out_valid_q;
	assign channel_index    = chan_idx_q;
	assign pulse_sixteenths = pulse_q;
	assign link_ok          = link_q;
	assign frame_count      = fcount_q;
	assign last_channel     = last_q;

endmodule

// ===== rtl/rcp_checker.sv =====
`timescale 1ns / 1ps

module rcp_checker import rcp_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic [7:0]  rx_byte,
	input logic        out_valid,
	input logic        out_stall,
	input logic [3:0]  channel_index,
	input logic [14:0] pulse_sixteenths,
	input logic        link_ok,
	input logic [15:0] frame_count,
	input logic        last_channel
);

	logic out_take;

	assign out_take = out_valid && !out_stall;

	// stalled result request holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(pulse_sixteenths)
			&& $stable(channel_index) && $stable(frame_count))
		else $error("stalled result changed");

	// results of one frame come in channel order with one frame count
	a_chan_order: assert property (@(posedge clk) disable iff (!arst_n)
		out_take && !last_channel |=> !out_valid
			|| (channel_index == $past(channel_index) + 4'd1
				&& frame_count == $past(frame_count)))
		else $error("channel order or frame count broken within frame");

	// input is held while a frame is still being emitted (checked after channels 0 to 7 are taken)
	a_stall_emit: assert property (@(posedge clk) disable iff (!arst_n)
		out_take && channel_index < 4'd8 |=> in_stall)
		else $error("input taken during frame emission");

	// pulse range and last marker
	a_pulse_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> pulse_sixteenths >= PULSE_MIN && pulse_sixteenths <= PULSE_MAX
			&& last_channel == (channel_index == LAST_CHANNEL))
		else $error("pulse out of range or last marker wrong");

endmodule

bind crc16_framed_rc_channel_parser_core rcp_checker u_rcp_checker (.*);
